@@ sv/wct_pkg.sv @@
`default_nettype none
package wct_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int QDEPTH_DEF    = 8;
  localparam int KDIM          = 5;
  localparam int NBANK         = KDIM - 1;

  localparam logic [31:0] THR_RESET  = 32'd3276825;
  localparam logic [23:0] DIMS_RESET = 24'd1638800;
  localparam logic [11:0] DIM_MIN    = 12'd5;
  localparam logic [7:0]  PIX_MAX    = 8'd255;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_COEF0 = 3'd1,
    REG_COEF1 = 3'd2,
    REG_COEF2 = 3'd3,
    REG_COEF3 = 3'd4,
    REG_COEF4 = 3'd5,
    REG_THR   = 3'd6,
    REG_DIMS  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic [11:0] out_row;
    logic [11:0] out_col;
    logic        from_filter;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic                  mode;
    logic [KDIM-1:0][39:0] coeff;
    logic [31:0]           thr;
    logic [23:0]           dims;
  } cfg_t;

  typedef struct packed {
    logic        interior;
    logic        border;
    logic [7:0]  pix;
    logic [11:0] row;
    logic [11:0] col;
    logic [11:0] irow;
    logic [11:0] icol;
  } meta_t;

  typedef logic [KDIM-1:0][KDIM-1:0][7:0] win_t;

  typedef struct packed {
    meta_t meta;
    win_t  win;
  } q_item_t;

endpackage
`default_nettype wire

@@ sv/wct_fifo.sv @@
`default_nettype none
module wct_fifo import wct_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire q_item_t                    push_item,
  input  wire logic                       pop,
  output      logic                       pop_valid,
  output      q_item_t                    pop_item,
  output      logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  q_item_t        mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH-1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH-1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_r];
  assign count     = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != CW'(DEPTH)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue underflow");

endmodule
`default_nettype wire

@@ sv/wct_front.sv @@
`default_nettype none
module wct_front import wct_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int QDEPTH    = QDEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire in_beat_t                    in_beat,
  input  wire cfg_t                        cfg,
  input  wire logic [$clog2(QDEPTH+1)-1:0] q_count,
  output      logic                        push,
  output      q_item_t                     push_item
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(QDEPTH+1);

  logic [11:0] row_r, row_nxt, col_r, col_nxt;
  logic [11:0] w, hgt, hw, r0, c0, c1, rr, cc;
  logic [12:0] r1, cn, rn;
  logic [CW:0] used;
  logic        acc;
  logic [AW-1:0] addr;
  meta_t       meta;

  logic        f0_v_r, f1_v_r;
  meta_t       f0_meta_r, f1_meta_r;
  logic [1:0]  f0_rot_r;
  logic [NBANK-1:0][7:0] rd_q;
  win_t        win_r, win_nxt;

  always_comb begin
    w   = cfg.dims[11:0];
    hgt = cfg.dims[23:12];
    if (w < DIM_MIN) w = DIM_MIN;
    else if (w > 12'(MAX_WIDTH)) w = 12'(MAX_WIDTH);
    if (hgt < DIM_MIN) hgt = DIM_MIN;
    else if (hgt > 12'(MAX_WIDTH)) hgt = 12'(MAX_WIDTH);
    hw = cfg.mode ? 12'd2 : 12'd1;
  end

  assign used     = {1'b0, q_count} + (CW+1)'(f0_v_r) + (CW+1)'(f1_v_r);
  assign in_stall = (used >= (CW+1)'(QDEPTH));
  assign acc      = in_valid && !in_stall;

  always_comb begin
    r0 = in_beat.frame_start ? '0 : row_r;
    c0 = in_beat.frame_start ? '0 : col_r;
    if (c0 >= w) begin
      c1 = '0;
      r1 = {1'b0, r0} + 13'd1;
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
    end
    rr = (r1 >= {1'b0, hgt}) ? '0 : r1[11:0];
    cc = c1;
    cn = {1'b0, cc} + 13'd1;
    rn = {1'b0, rr} + 13'd1;
    if (cn >= {1'b0, w}) begin
      col_nxt = '0;
      row_nxt = (rn >= {1'b0, hgt}) ? '0 : rn[11:0];
    end else begin
      col_nxt = cn[11:0];
      row_nxt = rr;
    end
    meta.interior = (rr >= (hw << 1)) && (cc >= (hw << 1));
    meta.border   = (rr < hw) || (rr >= hgt - hw) || (cc < hw) || (cc >= w - hw);
    meta.pix      = in_beat.pixel_in;
    meta.row      = rr;
    meta.col      = cc;
    meta.irow     = rr - hw;
    meta.icol     = cc - hw;
  end

  assign addr = cc[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
    end else begin
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      f0_v_r <= acc;
      f1_v_r <= f0_v_r;
    end
  end

  // one line bank per buffered row; bank rr[1:0] holds the current row
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [7:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc) begin
        rd_q[b] <= mem[addr];
        if (rr[1:0] == 2'(b)) mem[addr] <= in_beat.pixel_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f0_meta_r <= meta;
      f0_rot_r  <= rr[1:0];
    end
    if (f0_v_r) f1_meta_r <= f0_meta_r;
  end

  always_comb begin
    logic [1:0] sel;
    win_nxt = win_r;
    for (int y = 0; y < KDIM; y++) begin
      for (int x = 0; x < KDIM-1; x++) win_nxt[y][x] = win_r[y][x+1];
    end
    for (int y = 0; y < NBANK; y++) begin
      sel = f0_rot_r + 2'(y);
      win_nxt[y][KDIM-1] = rd_q[sel];
    end
    win_nxt[KDIM-1][KDIM-1] = f0_meta_r.pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (f0_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign push           = f1_v_r;
  assign push_item.meta = f1_meta_r;
  assign push_item.win  = win_r;

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> used < (CW+1)'(QDEPTH)) else $error("accepted beat without queue room");

endmodule
`default_nettype wire

@@ sv/wct_back.sv @@
`default_nettype none
module wct_back import wct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      q_valid,
  input  wire q_item_t   q_item,
  output      logic      q_pop,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_beat_t out_beat
);
  logic signed [7:0]  coef [KDIM][KDIM];
  logic signed [16:0] prod [KDIM][KDIM];
  logic signed [16:0] b0_prod_r [KDIM][KDIM];
  logic signed [19:0] rsum [KDIM];
  logic signed [19:0] b1_rsum_r [KDIM];
  logic signed [21:0] total, lo, hi;
  logic [7:0]  res;
  logic        b0_v_r, b1_v_r, int_v_r, bor_v_r;
  meta_t       b0_meta_r, b1_meta_r;
  logic [7:0]  int_pix_r, bor_pix_r;
  logic [11:0] int_row_r, int_col_r, bor_row_r, bor_col_r;
  logic        taken, adv;

  assign taken = out_valid && !out_stall;
  assign adv   = !(int_v_r || bor_v_r) || (taken && !(int_v_r && bor_v_r));
  assign q_pop = adv && q_valid;

  // mode 0: 3x3 kernel at lower-right, other taps forced to zero; mode 1: full 5x5 window
  always_comb begin
    for (int y = 0; y < KDIM; y++) begin
      for (int x = 0; x < KDIM; x++) begin
        if (cfg.mode) coef[y][x] = cfg.coeff[y][8*x +: 8];
        else if (y >= 2 && x >= 2) coef[y][x] = cfg.coeff[y-2][8*(x-2) +: 8];
        else coef[y][x] = '0;
        if (cfg.mode || (y >= 2 && x >= 2))
          prod[y][x] = coef[y][x] * $signed({1'b0, q_item.win[y][x]});
        else
          prod[y][x] = '0;
      end
    end
  end

  always_comb begin
    for (int y = 0; y < KDIM; y++) begin
      rsum[y] = '0;
      for (int x = 0; x < KDIM; x++) rsum[y] = rsum[y] + 20'(b0_prod_r[y][x]);
    end
    total = '0;
    for (int y = 0; y < KDIM; y++) total = total + 22'(b1_rsum_r[y]);
    lo = 22'($signed(cfg.thr[15:0]));
    hi = 22'($signed(cfg.thr[31:16]));
    if (total > hi) res = PIX_MAX;
    else if (total < lo) res = '0;
    else res = total[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      b1_v_r  <= 1'b0;
      int_v_r <= 1'b0;
      bor_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r  <= q_pop;
      b1_v_r  <= b0_v_r;
      int_v_r <= b1_v_r && b1_meta_r.interior;
      bor_v_r <= b1_v_r && b1_meta_r.border;
    end else if (taken && int_v_r) begin
      int_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_meta_r <= q_item.meta;
      b0_prod_r <= prod;
      b1_meta_r <= b0_meta_r;
      b1_rsum_r <= rsum;
      int_pix_r <= res;
      int_row_r <= b1_meta_r.irow;
      int_col_r <= b1_meta_r.icol;
      bor_pix_r <= b1_meta_r.pix;
      bor_row_r <= b1_meta_r.row;
      bor_col_r <= b1_meta_r.col;
    end
  end

  assign out_valid            = int_v_r || bor_v_r;
  assign out_beat.pixel_out   = int_v_r ? int_pix_r : bor_pix_r;
  assign out_beat.out_row     = int_v_r ? int_row_r : bor_row_r;
  assign out_beat.out_col     = int_v_r ? int_col_r : bor_col_r;
  assign out_beat.from_filter = int_v_r;
  assign out_beat.last_of_run = !(int_v_r && bor_v_r);

  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    taken && int_v_r && bor_v_r |=> out_valid && !int_v_r)
    else $error("border beat lost after interior beat");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !taken |=> out_valid) else $error("pending result dropped");

endmodule
`default_nettype wire

@@ sv/window_convolve_threshold_core.sv @@
// Path: accepted beat -> front f0, f1 -> queue -> back b0, b1 -> output regs.
// Throughput: one pixel per cycle when no stall (in_stall, out_stall) holds;
//   a pixel with interior and border results gives two beats, interior first.
// Line buffers: four single-port-read banks of MAX_WIDTH pixels, not cleared.
// Reset (sync, active low): counters, window, queue and config registers
//   return to defaults; no clearing pass, input is taken right away.
`default_nettype none
module window_convolve_threshold_core import wct_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int QDEPTH    = QDEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_beat_t    in_beat,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_beat_t   out_beat,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [39:0] cfg_wdata
);
  cfg_t    cfg_r;
  logic    push, pop, q_valid;
  q_item_t push_item, q_item;
  logic [$clog2(QDEPTH+1)-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= 1'b0;
      cfg_r.coeff <= '0;
      cfg_r.thr   <= THR_RESET;
      cfg_r.dims  <= DIMS_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_MODE:  cfg_r.mode     <= cfg_wdata[0];
        REG_COEF0: cfg_r.coeff[0] <= cfg_wdata;
        REG_COEF1: cfg_r.coeff[1] <= cfg_wdata;
        REG_COEF2: cfg_r.coeff[2] <= cfg_wdata;
        REG_COEF3: cfg_r.coeff[3] <= cfg_wdata;
        REG_COEF4: cfg_r.coeff[4] <= cfg_wdata;
        REG_THR:   cfg_r.thr      <= cfg_wdata[31:0];
        REG_DIMS:  cfg_r.dims     <= cfg_wdata[23:0];
      endcase
    end
  end

  wct_front #(.MAX_WIDTH(MAX_WIDTH), .QDEPTH(QDEPTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .cfg(cfg_r), .q_count(q_count), .push(push), .push_item(push_item)
  );

  wct_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(push_item),
    .pop(pop), .pop_valid(q_valid), .pop_item(q_item), .count(q_count)
  );

  wct_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

endmodule
`default_nettype wire
